### rtl/box3_pkg.sv
// Shared constants and types for the 3x3 box mean filter.
package box3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int SIZE_W  = 11;
	localparam int COORD_W = 10;
	localparam int ADDR_W  = $clog2(MAX_WIDTH);
	localparam int IDX_W   = 2;

	// a column of three pixels and the window of three columns
	localparam int COLSUM_W = PIX_W + 2;
	localparam int SUM_W    = PIX_W + 4;

	// floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT for x < 2**DIV9_SHIFT
	localparam int DIV9_SHIFT = 15;
	localparam int DIV9_MUL_W = 12;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL =
		DIV9_MUL_W'(((1 << DIV9_SHIFT) + 8) / 9);

	localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);
	localparam logic [SIZE_W-1:0] RST_WIDTH    = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] RST_HEIGHT   = SIZE_W'(480);

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]    pix_t;
	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [COLSUM_W-1:0] colsum_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// clamp a size register to [3, max] and return the last index
	function automatic coord_t last_index(input logic [SIZE_W-1:0] v,
	                                      input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] s;
		s = v;
		if (v < MIN_SIZE) begin
			s = MIN_SIZE;
		end else if (v > maxv) begin
			s = maxv;
		end
		return COORD_W'(s - SIZE_W'(1));
	endfunction

endpackage

### rtl/box_filter_3x3_mean_core.sv
// Streaming 3x3 box mean filter with two line stores.
//
// Pixels enter in raster order on pix_valid / pix_ready, one beat per pixel.
// Frame size comes from cfg writes: index 0 is width, index 1 is height,
// both clamped to 3..1024; writing either restarts the frame at row 0, column 0.
// Each interior pixel gives one beat on res_valid / res_ready carrying the
// floor of the nine-pixel mean, its row and column, and frame_last on the
// final interior result of the frame. Border pixels give no beat.
// One pixel is taken per cycle while pix_ready is high: the line stores are
// read at the accept edge and written back as the beat leaves stage 1, each a
// 1024 x 8 memory with one read port and one write port.
// Each of the three stages holds while the one after it is full and stalled,
// so input keeps flowing into empty slots while a result waits; pix_ready
// drops only once all stages are full and res_ready is low.
// Reset clears the counters, the window, the stage valids and restores the
// 640 x 480 size. Line store contents are not cleared; data read before the
// current frame has written it reaches only border beats, which give no result.
module box_filter_3x3_mean_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [box3_pkg::IDX_W-1:0]  cfg_index,
	input  logic [box3_pkg::SIZE_W-1:0] cfg_data,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [box3_pkg::PIX_W-1:0]  pixel,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [box3_pkg::PIX_W-1:0]  smoothed,
	output logic [box3_pkg::COORD_W-1:0] out_row,
	output logic [box3_pkg::COORD_W-1:0] out_col,
	output logic                        frame_last
);
	import box3_pkg::*;

	logic [SIZE_W-1:0] width_q, height_q;
	coord_t            w_last, h_last;
	coord_t            col_q, row_q;

	pix_t older_mem [MAX_WIDTH];
	pix_t newer_mem [MAX_WIDTH];

	// stage 1: pixel plus line store read data
	logic   v_s1, res_s1, last_s1;
	pix_t   pixel_s1, older_rd_s1, newer_rd_s1;
	coord_t col_s1, orow_s1, ocol_s1;

	// window column sums, oldest first
	colsum_t cs0_q, cs1_q;
	colsum_t cs_new;

	// stage 2: window sum of one interior pixel
	logic   v_s2, last_s2;
	sum_t   sum_s2;
	coord_t orow_s2, ocol_s2;

	logic [SUM_W+DIV9_MUL_W-1:0] quot_prod;
	logic                        res_valid_q, frame_last_q;
	pix_t                        smoothed_q;
	coord_t                      out_row_q, out_col_q;

	logic pix_go, s1_go, s2_go, rdy_s2, rdy_o;

	assign w_last = last_index(width_q, MAX_W_SIZE);
	assign h_last = last_index(height_q, MAX_H_SIZE);

	assign rdy_o     = !res_valid_q || res_ready;
	assign rdy_s2    = !v_s2 || rdy_o;
	assign pix_ready = !v_s1 || rdy_s2;
	assign pix_go    = pix_valid && pix_ready;
	assign s1_go     = v_s1 && rdy_s2;
	assign s2_go     = v_s2 && rdy_o;

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (pix_go) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	// line stores: read on accept, write back as the beat leaves stage 1
	always_ff @(posedge clk) begin
		if (pix_go) begin
			older_rd_s1 <= older_mem[col_q[ADDR_W-1:0]];
			newer_rd_s1 <= newer_mem[col_q[ADDR_W-1:0]];
		end
		if (s1_go) begin
			older_mem[col_s1[ADDR_W-1:0]] <= newer_rd_s1;
			newer_mem[col_s1[ADDR_W-1:0]] <= pixel_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pix_go) begin
			pixel_s1 <= pixel;
			col_s1   <= col_q;
			res_s1   <= (row_q >= COORD_W'(2)) && (col_q >= COORD_W'(2));
			last_s1  <= (row_q == h_last) && (col_q == w_last);
			orow_s1  <= row_q - COORD_W'(1);
			ocol_s1  <= col_q - COORD_W'(1);
		end
	end

	assign cs_new = COLSUM_W'(older_rd_s1) + COLSUM_W'(newer_rd_s1) + COLSUM_W'(pixel_s1);

	// window shift and stage 2 payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs0_q <= '0;
			cs1_q <= '0;
		end else if (s1_go) begin
			cs0_q <= cs1_q;
			cs1_q <= cs_new;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sum_s2  <= SUM_W'(cs0_q) + SUM_W'(cs1_q) + SUM_W'(cs_new);
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			last_s2 <= last_s1;
		end
	end

	assign quot_prod = (SUM_W+DIV9_MUL_W)'(sum_s2) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);

	always_ff @(posedge clk) begin
		if (s2_go) begin
			smoothed_q   <= quot_prod[DIV9_SHIFT +: PIX_W];
			out_row_q    <= orow_s2;
			out_col_q    <= ocol_s2;
			frame_last_q <= last_s2;
		end
	end

	// stage valids; border beats drop out at stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pix_go) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				v_s2 <= res_s1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign smoothed   = smoothed_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last)
		else $error("column counter beyond row end");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last)
		else $error("row counter beyond frame end");

	a_s2_interior: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (orow_s2 != '0) && (ocol_s2 != '0))
		else $error("border pixel reached the window sum stage");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> pix_ready)
		else $error("input stalled with stage 1 empty");

endmodule
